/* src/kbrp_pkg.sv */
// key bundle record parser package: section and verdict codes, record layout
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package kbrp_pkg;

  typedef enum logic [3:0] {
    SecVersion  = 4'd0,
    SecClientId = 4'd1,
    SecIdAlg    = 4'd2,
    SecIdLen    = 4'd3,
    SecIdKey    = 4'd4,
    SecKexAlg   = 4'd5,
    SecKexLen   = 4'd6,
    SecKexKey   = 4'd7,
    SecExpiry   = 4'd8,
    SecFpAlg    = 4'd9,
    SecFpLen    = 4'd10,
    SecFp       = 4'd11,
    SecSigAlg   = 4'd12,
    SecSigLen   = 4'd13,
    SecSig      = 4'd14,
    SecDone     = 4'd15
  } section_e;

  typedef enum logic [2:0] {
    VerdictPending   = 3'd0,
    VerdictOk        = 3'd1,
    VerdictTruncated = 3'd2,
    VerdictZeroLen   = 3'd3,
    VerdictTrailing  = 3'd4
  } verdict_e;

  localparam int unsigned ByteW = 8;
  localparam int unsigned OffW  = 16;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } in_item_t;

  typedef struct packed {
    section_e         section;
    logic [ByteW-1:0] data;
    logic [OffW-1:0]  offset;
    verdict_e         verdict;
  } result_t;

  // fixed section size, zero for a payload sized by the preceding length field
  function automatic logic [OffW-1:0] section_size(section_e s);
    logic [OffW-1:0] size;
    unique case (s)
      SecVersion, SecIdAlg, SecKexAlg, SecFpAlg, SecSigAlg: size = OffW'(1);
      SecClientId:                                         size = OffW'(4);
      SecIdLen, SecKexLen, SecFpLen, SecSigLen:            size = OffW'(2);
      SecExpiry:                                           size = OffW'(8);
      SecIdKey, SecKexKey, SecFp, SecSig, SecDone:         size = '0;
      default:                                             size = '0;
    endcase
    return size;
  endfunction

  function automatic logic is_length_section(section_e s);
    return (s == SecIdLen) || (s == SecKexLen) || (s == SecFpLen) || (s == SecSigLen);
  endfunction

endpackage
`default_nettype wire

/* src/kbrp_in_stage.sv */
// input register stage of the key bundle record parser
// depends on kbrp_pkg
`timescale 1ns / 1ps
`default_nettype none
module kbrp_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  input  wire logic              advance_i,
  output logic                   stall_o,
  output logic                   valid_o,
  output kbrp_pkg::in_item_t     item_o
);
  import kbrp_pkg::*;

  logic     valid_q, valid_d;
  logic     accept;
  in_item_t item_q;

  assign stall_o = valid_q & ~advance_i;
  assign accept  = valid_i & ~stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data <= data_byte_i;
      item_q.last <= last_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

/* src/kbrp_parse.sv */
// parse state and per-byte tagging of the key bundle record parser
// depends on kbrp_pkg
`timescale 1ns / 1ps
`default_nettype none
module kbrp_parse (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire kbrp_pkg::in_item_t item_i,
  output kbrp_pkg::result_t       result_o
);
  import kbrp_pkg::*;

  section_e        sec_q, sec_d;
  logic [OffW-1:0] off_q, off_d;
  logic [OffW-1:0] len_q, len_d;
  verdict_e        err_q, err_d;
  logic [OffW-1:0] size;
  logic [OffW:0]   off_next;
  logic            len_sec;

  assign len_sec  = is_length_section(sec_q);
  assign off_next = {1'b0, off_q} + (OffW+1)'(1);

  always_comb begin
    sec_d = sec_q;
    off_d = off_q;
    len_d = len_q;
    err_d = err_q;
    size  = section_size(sec_q);
    result_o.section = SecDone;
    result_o.data    = item_i.data;
    result_o.offset  = '0;
    result_o.verdict = VerdictPending;

    if (err_q != VerdictPending) begin
      // error latched, byte ignored
    end else if (sec_q == SecDone) begin
      err_d = VerdictTrailing;
    end else begin
      result_o.section = sec_q;
      result_o.offset  = off_q;
      if (len_sec) begin
        if (off_q == '0) begin
          len_d = {item_i.data, 8'h00};
        end else begin
          len_d = len_q | {8'h00, item_i.data};
        end
      end
      if (size == '0) begin
        size = len_d;
      end
      if (off_next >= {1'b0, size}) begin
        if (len_sec && (len_d == '0)) begin
          err_d = VerdictZeroLen;
        end else begin
          sec_d = section_e'(sec_q + 4'd1);
          off_d = '0;
        end
      end else begin
        off_d = off_next[OffW-1:0];
      end
    end

    if (item_i.last) begin
      priority if (err_d != VerdictPending) begin
        result_o.verdict = err_d;
      end else if (sec_d == SecDone) begin
        result_o.verdict = VerdictOk;
      end else begin
        result_o.verdict = VerdictTruncated;
      end
      sec_d = SecVersion;
      off_d = '0;
      len_d = '0;
      err_d = VerdictPending;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q <= SecVersion;
      off_q <= '0;
      len_q <= '0;
      err_q <= VerdictPending;
    end else if (advance_i) begin
      sec_q <= sec_d;
      off_q <= off_d;
      len_q <= len_d;
      err_q <= err_d;
    end
  end

endmodule
`default_nettype wire

/* src/kbrp_out_stage.sv */
// result register stage of the key bundle record parser
// depends on kbrp_pkg
`timescale 1ns / 1ps
`default_nettype none
module kbrp_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire kbrp_pkg::result_t result_i,
  input  wire logic              stall_i,
  output logic                   advance_o,
  output logic                   valid_o,
  output kbrp_pkg::result_t      result_o
);
  import kbrp_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign advance_o = valid_i & (~valid_q | ~stall_i);

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

/* src/key_bundle_record_parser_unit.sv */
// key bundle record parser: tags each byte with its section and offset, and the last byte with a verdict
// throughput 1 byte per cycle while out_stall_i is low
// each byte passes through one input register, then one result register, around the per-byte tagging logic
// asynchronous active-low reset returns the parser to the version byte, no error latched
// depends on kbrp_pkg, kbrp_in_stage, kbrp_parse, kbrp_out_stage
`timescale 1ns / 1ps
`default_nettype none
module key_bundle_record_parser_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [3:0]      section_o,
  output logic [7:0]      byte_out_o,
  output logic [15:0]     section_offset_o,
  output logic [2:0]      verdict_o
);
  import kbrp_pkg::*;

  logic     item_valid;
  logic     advance;
  in_item_t item;
  result_t  result_next;
  result_t  result;

  kbrp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .advance_i   (advance),
    .stall_o     (in_stall_o),
    .valid_o     (item_valid),
    .item_o      (item)
  );

  kbrp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .result_o  (result_next)
  );

  kbrp_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (item_valid),
    .result_i  (result_next),
    .stall_i   (out_stall_i),
    .advance_o (advance),
    .valid_o   (out_valid_o),
    .result_o  (result)
  );

  assign section_o        = result.section;
  assign byte_out_o       = result.data;
  assign section_offset_o = result.offset;
  assign verdict_o        = result.verdict;

endmodule
`default_nettype wire
